[sv/rgb_to_hsv_scaled_assert.svh]
// Assertion macros for the RGB to HSV converter.
`ifndef RGB_TO_HSV_SCALED_ASSERT_SVH
`define RGB_TO_HSV_SCALED_ASSERT_SVH

`ifndef SYNTH

`define R2H_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("r2h: implication check failed");

`define R2H_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("r2h: next-cycle check failed");

`else

`define R2H_ASSERT_IMPL(label, clk, rst, ante, cons)

`define R2H_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[sv/r2h_pkg.sv]
// Shared widths, constants and stage payload types for the RGB to HSV converter.
`default_nettype none

package r2h_pkg;

   localparam int PIX_W     = 8;
   localparam int HUE_W     = 12;
   localparam int SV_W      = 10;
   localparam int HUE_NUM_W = 20;
   localparam int SAT_NUM_W = 18;
   localparam int QUO_W     = 12;

   // floor(x*1000/255) estimate: x*1028000 >> 18, low by at most one
   localparam logic [19:0] VAL_RECIP = 20'd1028000;
   localparam int          VAL_SHIFT = 18;
   localparam int          VAL_REM_W = 18;

   typedef struct packed {
      logic [HUE_NUM_W-1:0] hue_num;
      logic [PIX_W-1:0]     hue_den;
      logic [SAT_NUM_W-1:0] sat_num;
      logic [PIX_W-1:0]     sat_den;
      logic [SV_W-1:0]      val_est;
      logic                 grey;
   } front_type;

   typedef struct packed {
      logic             grey;
      logic [PIX_W-1:0] hi;
      logic [SV_W-1:0]  val_est;
   } hue_side_type;

endpackage

`default_nettype wire

[sv/r2h_front.sv]
// Front stages: max/min and sector select, then numerators and value estimate.
`default_nettype none

module r2h_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      en,
   input  wire logic                      in_valid,
   input  wire logic [r2h_pkg::PIX_W-1:0] red,
   input  wire logic [r2h_pkg::PIX_W-1:0] green,
   input  wire logic [r2h_pkg::PIX_W-1:0] blue,
   output logic                           out_valid,
   output r2h_pkg::front_type             out_data
);

   typedef enum logic [1:0] {
      BASE_0    = 2'd0,
      BASE_1200 = 2'd1,
      BASE_2400 = 2'd2,
      BASE_3600 = 2'd3
   } base_type;

   localparam int BASE_W = 12;

   // stage 1
   logic                      s1_valid_ff;
   logic [r2h_pkg::PIX_W-1:0] s1_hi_ff, s1_hi_in;
   logic [r2h_pkg::PIX_W-1:0] s1_d_ff, s1_d_in;
   logic [r2h_pkg::PIX_W-1:0] s1_diff_ff, s1_diff_in;
   logic                      s1_neg_ff, s1_neg_in;
   base_type                  s1_base_ff, s1_base_in;

   // stage 2
   logic                      s2_valid_ff;
   r2h_pkg::front_type        s2_data_ff, s2_data_in;

   logic [r2h_pkg::PIX_W-1:0] lo;
   logic [BASE_W-1:0]         base_val;
   logic [r2h_pkg::HUE_NUM_W-1:0] base_term, diff_term;
   logic [27:0]               val_prod;

   always_comb begin
      lo = red;
      if (green < lo) begin
         lo = green;
      end
      if (blue < lo) begin
         lo = blue;
      end
      if (red >= green && red >= blue) begin
         s1_hi_in = red;
         if (green >= blue) begin
            s1_diff_in = green - blue;
            s1_neg_in  = 1'b0;
            s1_base_in = BASE_0;
         end else begin
            s1_diff_in = blue - green;
            s1_neg_in  = 1'b1;
            s1_base_in = BASE_3600;
         end
      end else if (green >= blue) begin
         s1_hi_in   = green;
         s1_base_in = BASE_1200;
         if (blue >= red) begin
            s1_diff_in = blue - red;
            s1_neg_in  = 1'b0;
         end else begin
            s1_diff_in = red - blue;
            s1_neg_in  = 1'b1;
         end
      end else begin
         s1_hi_in   = blue;
         s1_base_in = BASE_2400;
         if (red >= green) begin
            s1_diff_in = red - green;
            s1_neg_in  = 1'b0;
         end else begin
            s1_diff_in = green - red;
            s1_neg_in  = 1'b1;
         end
      end
      s1_d_in = s1_hi_in - lo;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_hi_ff   <= s1_hi_in;
         s1_d_ff    <= s1_d_in;
         s1_diff_ff <= s1_diff_in;
         s1_neg_ff  <= s1_neg_in;
         s1_base_ff <= s1_base_in;
      end
   end

   always_comb begin
      unique case (s1_base_ff)
         BASE_0:    base_val = 12'd0;
         BASE_1200: base_val = 12'd1200;
         BASE_2400: base_val = 12'd2400;
         BASE_3600: base_val = 12'd3600;
         default:   base_val = 12'd0;
      endcase
      base_term = r2h_pkg::HUE_NUM_W'(base_val) * r2h_pkg::HUE_NUM_W'(s1_d_ff);
      diff_term = r2h_pkg::HUE_NUM_W'(s1_diff_ff) * r2h_pkg::HUE_NUM_W'(10'd600);
      val_prod  = 28'(s1_hi_ff) * 28'(r2h_pkg::VAL_RECIP);

      s2_data_in.hue_num = s1_neg_ff ? (base_term - diff_term) : (base_term + diff_term);
      s2_data_in.hue_den = s1_d_ff;
      s2_data_in.sat_num = r2h_pkg::SAT_NUM_W'(s1_d_ff) * r2h_pkg::SAT_NUM_W'(10'd1000);
      s2_data_in.sat_den = s1_hi_ff;
      s2_data_in.val_est = val_prod[r2h_pkg::VAL_SHIFT +: r2h_pkg::SV_W];
      s2_data_in.grey    = (s1_d_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_data_ff <= s2_data_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_data  = s2_data_ff;

endmodule

`default_nettype wire

[sv/r2h_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with a sideband.
`default_nettype none

module r2h_div #(
   parameter int NUM_W  = 20,
   parameter int DEN_W  = 8,
   parameter int QUO_W  = 12,
   parameter int SIDE_W = 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_valid,
   input  wire logic [NUM_W-1:0]  num,
   input  wire logic [DEN_W-1:0]  den,
   input  wire logic [SIDE_W-1:0] side,
   output logic                   out_valid,
   output logic [QUO_W-1:0]       quo,
   output logic [SIDE_W-1:0]      out_side
);

   // num must be below den * 2**QUO_W
   localparam int CW = DEN_W + QUO_W;

   logic              vld_ff  [QUO_W];
   logic [CW-1:0]     rem_ff  [QUO_W];
   logic [DEN_W-1:0]  den_ff  [QUO_W];
   logic [QUO_W-1:0]  quo_ff  [QUO_W];
   logic [SIDE_W-1:0] side_ff [QUO_W];

   for (genvar s = 0; s < QUO_W; s++) begin : g_stage
      localparam int B = QUO_W - 1 - s;

      logic              vld_cur;
      logic [CW-1:0]     rem_cur, trial, rem_in;
      logic [DEN_W-1:0]  den_cur;
      logic [QUO_W-1:0]  quo_cur, quo_in;
      logic [SIDE_W-1:0] side_cur;
      logic              ge;

      if (s == 0) begin : g_first
         assign vld_cur  = in_valid;
         assign rem_cur  = CW'(num);
         assign den_cur  = den;
         assign quo_cur  = '0;
         assign side_cur = side;
      end else begin : g_next
         assign vld_cur  = vld_ff[s-1];
         assign rem_cur  = rem_ff[s-1];
         assign den_cur  = den_ff[s-1];
         assign quo_cur  = quo_ff[s-1];
         assign side_cur = side_ff[s-1];
      end

      always_comb begin
         trial     = CW'(den_cur) << B;
         ge        = (rem_cur >= trial);
         rem_in    = ge ? (rem_cur - trial) : rem_cur;
         quo_in    = quo_cur;
         quo_in[B] = ge;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en) begin
            vld_ff[s] <= vld_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            quo_ff[s]  <= quo_in;
            side_ff[s] <= side_cur;
         end
      end

      if (s < QUO_W - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[s] <= rem_in;
               den_ff[s] <= den_cur;
            end
         end
      end
   end

   assign out_valid = vld_ff[QUO_W-1];
   assign quo       = quo_ff[QUO_W-1];
   assign out_side  = side_ff[QUO_W-1];

endmodule

`default_nettype wire

[sv/rgb_to_hsv_scaled.sv]
// Top level of the RGB to HSV converter: front stages, two dividers, output register.
//
//   channel   dir   handshake               payload
//   req_      in    req_tvalid/req_tready   red[7:0] green[15:8] blue[23:16]
//   rsp_      out   rsp_tvalid/rsp_tready   hue[11:0] sat[21:12] val[31:22]
//
// One pixel per clock while the output is not stalled; stages: 2 front, 12 divider, 1 output.
// The divider depth is set by the 12-bit quotient, one bit per divider stage.
// Synchronous reset clears all valid bits; payload registers are not reset.
// All stages advance together when the output register is empty or taken;
// a stall freezes the whole pipeline, so nothing is lost or repeated.
`default_nettype none

module rgb_to_hsv_scaled (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // red, green, blue
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata    // hue_tenths, sat_permille, val_permille
);

   `include "rgb_to_hsv_scaled_assert.svh"

   logic                          en;
   logic                          front_vld;
   r2h_pkg::front_type            front_data;
   r2h_pkg::hue_side_type         hue_side_in, hue_side_out;
   logic                          hue_vld, sat_vld;
   logic [r2h_pkg::QUO_W-1:0]     hue_quo, sat_quo;
   logic                          sat_grey;

   logic [r2h_pkg::VAL_REM_W-1:0] val_x, val_back, val_rem;
   logic [r2h_pkg::SV_W-1:0]      val_fix;

   logic                          rsp_valid_ff;
   logic [r2h_pkg::HUE_W-1:0]     hue_ff, hue_in;
   logic [r2h_pkg::SV_W-1:0]      sat_ff, sat_in;
   logic [r2h_pkg::SV_W-1:0]      val_ff, val_in;

   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   r2h_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .red       (req_tdata[7:0]),
      .green     (req_tdata[15:8]),
      .blue      (req_tdata[23:16]),
      .out_valid (front_vld),
      .out_data  (front_data)
   );

   always_comb begin
      hue_side_in.grey    = front_data.grey;
      hue_side_in.hi      = front_data.sat_den;
      hue_side_in.val_est = front_data.val_est;
   end

   r2h_div #(
      .NUM_W  (r2h_pkg::HUE_NUM_W),
      .DEN_W  (r2h_pkg::PIX_W),
      .QUO_W  (r2h_pkg::QUO_W),
      .SIDE_W ($bits(r2h_pkg::hue_side_type))
   ) u_hue_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (front_vld),
      .num       (front_data.hue_num),
      .den       (front_data.hue_den),
      .side      (hue_side_in),
      .out_valid (hue_vld),
      .quo       (hue_quo),
      .out_side  (hue_side_out)
   );

   r2h_div #(
      .NUM_W  (r2h_pkg::SAT_NUM_W),
      .DEN_W  (r2h_pkg::PIX_W),
      .QUO_W  (r2h_pkg::QUO_W),
      .SIDE_W (1)
   ) u_sat_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (front_vld),
      .num       (front_data.sat_num),
      .den       (front_data.sat_den),
      .side      (front_data.grey),
      .out_valid (sat_vld),
      .quo       (sat_quo),
      .out_side  (sat_grey)
   );

   // value estimate is low by at most one; fix with one remainder check
   always_comb begin
      val_x    = r2h_pkg::VAL_REM_W'(hue_side_out.hi) * r2h_pkg::VAL_REM_W'(10'd1000);
      val_back = (r2h_pkg::VAL_REM_W'(hue_side_out.val_est) << 8)
                 - r2h_pkg::VAL_REM_W'(hue_side_out.val_est);
      val_rem  = val_x - val_back;
      val_fix  = (val_rem >= r2h_pkg::VAL_REM_W'(255)) ? (hue_side_out.val_est + 1'b1)
                                                       : hue_side_out.val_est;
      hue_in   = hue_side_out.grey ? '0 : hue_quo[r2h_pkg::HUE_W-1:0];
      sat_in   = sat_grey ? '0 : sat_quo[r2h_pkg::SV_W-1:0];
      val_in   = val_fix;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= hue_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hue_ff <= hue_in;
         sat_ff <= sat_in;
         val_ff <= val_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {val_ff, sat_ff, hue_ff};

   `R2H_ASSERT_IMPL(a_div_lockstep, clock, reset, 1'b1, (hue_vld == sat_vld) && (sat_grey == hue_side_out.grey || !hue_vld))
   `R2H_ASSERT_NEXT(a_out_load, clock, reset, hue_vld && en, rsp_tvalid)
   `R2H_ASSERT_IMPL(a_out_range, clock, reset, rsp_valid_ff, (hue_ff < 12'd3600) && (sat_ff <= 10'd1000) && (val_ff <= 10'd1000))
   `R2H_ASSERT_IMPL(a_grey_hue, clock, reset, rsp_valid_ff && (sat_ff == '0), hue_ff == '0)

endmodule

`default_nettype wire

[dv/rgb_to_hsv_scaled_chk.sv]
// Checker for rgb_to_hsv_scaled: predicts each pixel's HSV triple and compares the results.
module rgb_to_hsv_scaled_chk (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,    // red, green, blue
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,    // hue_tenths, sat_permille, val_permille
   output int          mismatches,
   output int          outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [r2h_pkg::SV_W-1:0]  val_permille;
      logic [r2h_pkg::SV_W-1:0]  sat_permille;
      logic [r2h_pkg::HUE_W-1:0] hue_tenths;
   } hsv_type;

   hsv_type expected_hsv[$];

   function automatic hsv_type rgb_to_hsv_expected(input logic [23:0] pix);
      int      r, g, b, hi, lo, d, num;
      hsv_type res;
      r = int'(pix[7:0]);
      g = int'(pix[15:8]);
      b = int'(pix[23:16]);
      hi = (r > g) ? r : g;
      hi = (b > hi) ? b : hi;
      lo = (r < g) ? r : g;
      lo = (b < lo) ? b : lo;
      d = hi - lo;
      res.val_permille = r2h_pkg::SV_W'((hi * 1000) / 255);
      res.sat_permille = (hi == 0) ? '0 : r2h_pkg::SV_W'((d * 1000) / hi);
      if (d == 0) begin
         res.hue_tenths = '0;
      end else begin
         if (r >= g && r >= b) begin
            num = 600 * (g - b);
            if (num < 0) begin
               num = num + 3600 * d;   // wrap negative red-sector hue
            end
         end else if (g >= b) begin
            num = 1200 * d + 600 * (b - r);
         end else begin
            num = 2400 * d + 600 * (r - g);
         end
         res.hue_tenths = r2h_pkg::HUE_W'(num / d);
      end
      return res;
   endfunction

   always @(posedge clock) begin : track
      hsv_type want;
      hsv_type got;
      int      errs;
      if (reset) begin
         expected_hsv.delete();
         mismatches  <= 0;
         outstanding <= 0;
      end else begin
         errs = 0;
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_hsv.size() == 0) begin
               $error("result transaction with no pixel outstanding: %h", rsp_tdata);
               errs++;
            end else begin
               want = expected_hsv.pop_front();
               if (got.hue_tenths !== want.hue_tenths) begin
                  $error("hue_tenths: expected %0d, actual %0d",
                         want.hue_tenths, got.hue_tenths);
                  errs++;
               end
               if (got.sat_permille !== want.sat_permille) begin
                  $error("sat_permille: expected %0d, actual %0d",
                         want.sat_permille, got.sat_permille);
                  errs++;
               end
               if (got.val_permille !== want.val_permille) begin
                  $error("val_permille: expected %0d, actual %0d",
                         want.val_permille, got.val_permille);
                  errs++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            expected_hsv.push_back(rgb_to_hsv_expected(req_tdata));
         end
         mismatches  <= mismatches + errs;
         outstanding <= expected_hsv.size();
      end
   end

endmodule

[dv/rgb_to_hsv_scaled_tb.sv]
// Testbench top for rgb_to_hsv_scaled: clock, reset, pixel stimulus, backpressure and verdict.
module rgb_to_hsv_scaled_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int ITEMS_PER_RUN = 112;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;

   int mismatches;
   int outstanding;
   int cycle_count   = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;

   rgb_to_hsv_scaled dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   rgb_to_hsv_scaled_chk chk (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_tready <= !reset && ($urandom_range(99) >= rsp_stall_pct);
   end

   task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
      req_tdata  <= {b, g, r};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic send_random_pixel();
      logic [7:0] c[3];
      logic [7:0] top;
      int         k;
      for (int i = 0; i < 3; i++) c[i] = 8'($urandom_range(255));
      case ($urandom_range(9))
         5: begin
            c[1] = c[0];
            c[2] = c[0];
         end
         6: begin
            k = $urandom_range(2);
            top = 8'($urandom_range(255));
            c[k] = top;
            c[(k + 1) % 3] = top;
            c[(k + 2) % 3] = 8'($urandom_range(top));
         end
         7: begin
            for (int i = 0; i < 3; i++) begin
               k = $urandom_range(2);
               c[i] = (k == 0) ? 8'd0 : (k == 1) ? 8'd255 : c[i];
            end
         end
         8: begin
            top = 8'($urandom_range(253, 2));
            for (int i = 0; i < 3; i++) c[i] = 8'(top + $urandom_range(2) - 1);
         end
         9: begin
            k = $urandom_range(2);
            c[k] = 8'd0;
            c[(k + 1 + $urandom_range(1)) % 3] = 8'd255;
         end
         default: ;
      endcase
      send_pixel(c[0], c[1], c[2]);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // black, white, grey, primaries and secondaries (tie order), sector edges
      send_pixel(8'd0,   8'd0,   8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd128, 8'd128, 8'd128);
      send_pixel(8'd1,   8'd1,   8'd1);
      send_pixel(8'd255, 8'd0,   8'd0);
      send_pixel(8'd0,   8'd255, 8'd0);
      send_pixel(8'd0,   8'd0,   8'd255);
      send_pixel(8'd255, 8'd255, 8'd0);
      send_pixel(8'd0,   8'd255, 8'd255);
      send_pixel(8'd255, 8'd0,   8'd255);
      send_pixel(8'd255, 8'd0,   8'd1);
      send_pixel(8'd255, 8'd254, 8'd0);
      send_pixel(8'd1,   8'd0,   8'd0);
      send_pixel(8'd0,   8'd0,   8'd1);
      send_pixel(8'd255, 8'd254, 8'd253);
      send_pixel(8'd10,  8'd200, 8'd50);
      send_pixel(8'd200, 8'd201, 8'd10);
      send_pixel(8'd30,  8'd20,  8'd250);
      send_pixel(8'd20,  8'd30,  8'd250);
      send_pixel(8'd255, 8'd128, 8'd128);
      send_pixel(8'd170, 8'd85,  8'd0);
      drain_results();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  rsp_stall_pct <= 0;  end
            1: begin send_idle_pct = 45; rsp_stall_pct <= 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct <= 45; end
            default: begin send_idle_pct = 27; rsp_stall_pct <= 27; end
         endcase
         repeat (ITEMS_PER_RUN) send_random_pixel();
         drain_results();
      end

      repeat (20) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
